@@ sv/sml_pkg.sv @@
// ----------------------------------------------------------------------------
// sml_pkg: shared types and codes of the set membership table
// Item layouts, status and mode codes, and the output load request.
// ----------------------------------------------------------------------------
package sml_pkg;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_DUP      = 3'd1,
		ST_NOTFOUND = 3'd2,
		ST_FULL     = 3'd3,
		ST_BADIDX   = 3'd4,
		ST_BUSY     = 3'd5,
		ST_TOOLARGE = 3'd6,
		ST_NOOPEN   = 3'd7
	} status_t;

	typedef enum logic [1:0] {
		MODE_OPEN = 2'd0,
		MODE_ADD  = 2'd1,
		MODE_FIND = 2'd2,
		MODE_LIST = 2'd3
	} mode_t;

	typedef logic [4:0] setno_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic [15:0] value;
		logic [5:0]  declared_size;
		logic [7:0]  set_a;
		logic [7:0]  set_b;
	} in_item_t;

	typedef struct packed {
		status_t     status;
		setno_t      set_number;
		logic [15:0] element;
		logic        last;
		logic        set_closed;
	} out_item_t;

	typedef struct packed {
		logic      load;
		out_item_t item;
	} out_load_t;

endpackage

@@ sv/sml_if.sv @@
// ----------------------------------------------------------------------------
// sml_if: item channels of the set membership table
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface sml_in_if;
	logic              valid;
	logic              ready;
	sml_pkg::in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface sml_out_if;
	logic               valid;
	logic               ready;
	sml_pkg::out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ sv/sml_ram.sv @@
// ----------------------------------------------------------------------------
// sml_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sml_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ sv/sml_out_stage.sv @@
// ----------------------------------------------------------------------------
// sml_out_stage: result output register
// Holds one result item until the sink takes it.
// ----------------------------------------------------------------------------
module sml_out_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  sml_pkg::out_load_t ld,
	output logic               free,
	sml_out_if.source          result
);

	logic               vld_q;
	sml_pkg::out_item_t data_q;

	assign free = !vld_q || result.ready;
	assign result.valid = vld_q;
	assign result.data = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (ld.load) begin
			vld_q <= 1'b1;
		end else if (result.ready) begin
			vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld.load) begin
			data_q <= ld.item;
		end
	end

endmodule

@@ sv/set_membership_table_unit.sv @@
// ----------------------------------------------------------------------------
// set_membership_table_unit: table of disjoint value sets
// Open, fill, search and list sets; one RAM compare unit scans stored values.
// ----------------------------------------------------------------------------
// Open items and errors found in S_DECODE go straight to S_RESP, which waits for the output register.
// Find and add: S_SIZE and S_SIZE_CHK read the size of each completed set, S_ELEM
//   compares its stored values until a hit or the last set, then S_SCAN_DONE forms the result.
// List: S_LSZA and S_LSZB read both set sizes, then S_LREQ and S_LOUT send each listed value.
// One item at a time; ready only while idle.
// Reset clears the sequencer and set count; stores need no clearing pass.
module set_membership_table_unit #(
	parameter int MAX_SETS = 16,
	parameter int SET_CAP  = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	sml_in_if.sink    item,
	sml_out_if.source result
);

	localparam int SIW = $clog2(MAX_SETS);
	localparam int EW  = $clog2(SET_CAP);
	localparam int SW  = $clog2(MAX_SETS + 1);
	localparam int SZW = $clog2(SET_CAP + 1);
	localparam int ELEM_DEPTH = MAX_SETS * (1 << EW);

	typedef enum logic [11:0] {
		S_IDLE      = 12'b0000_0000_0001,
		S_DECODE    = 12'b0000_0000_0010,
		S_SIZE      = 12'b0000_0000_0100,
		S_SIZE_CHK  = 12'b0000_0000_1000,
		S_ELEM      = 12'b0000_0001_0000,
		S_SCAN_DONE = 12'b0000_0010_0000,
		S_RESP      = 12'b0000_0100_0000,
		S_LSZA      = 12'b0000_1000_0000,
		S_LSZB      = 12'b0001_0000_0000,
		S_LSTART    = 12'b0010_0000_0000,
		S_LREQ      = 12'b0100_0000_0000,
		S_LOUT      = 12'b1000_0000_0000
	} state_t;

	state_t             state_q;
	sml_pkg::in_item_t  req_q;
	sml_pkg::out_item_t res_q;
	logic [SW-1:0]      closed_q;
	logic               building_q;
	logic [SZW-1:0]     target_q;
	logic [SZW-1:0]     fill_q;
	logic [SW-1:0]      s_q;
	logic [SZW-1:0]     e_q;
	logic [SZW-1:0]     lim_q;
	logic               cmp_vld_q;
	logic [SIW-1:0]     cmp_set_q;
	logic [SW-1:0]      hit_q;
	logic [SZW-1:0]     na_q;
	logic [SZW-1:0]     nb_q;
	logic [SZW:0]       rem_q;

	logic [15:0]        elem_rd;
	logic [SZW-1:0]     size_rd;
	logic               elem_we;
	logic               size_we;
	logic [SZW-1:0]     size_wdata;
	logic [SIW-1:0]     size_raddr;
	logic [7:0]         sa_idx;
	logic [7:0]         sb_idx;
	logic               sa_live;
	logic               sb_live;
	logic [SZW-1:0]     nb_now;
	logic [SZW:0]       tot_now;
	logic               hit_now;
	logic               open_zero;
	logic               add_close;
	logic               bad_idx;
	logic               table_full;
	logic               out_free;
	sml_pkg::out_load_t ld;

	function automatic sml_pkg::out_item_t mk_res(sml_pkg::status_t st,
			logic [SW-1:0] setno, logic closed);
		sml_pkg::out_item_t r;
		r.status     = st;
		r.set_number = sml_pkg::setno_t'(setno);
		r.element    = '0;
		r.last       = 1'b1;
		r.set_closed = closed;
		return r;
	endfunction

	assign item.ready = (state_q == S_IDLE);

	assign sa_idx = req_q.set_a - 8'd1;
	assign sb_idx = req_q.set_b - 8'd1;
	assign sa_live = sa_idx < 8'(closed_q);
	assign sb_live = sb_idx < 8'(closed_q);
	assign nb_now = sb_live ? size_rd : '0;
	assign tot_now = {1'b0, na_q} + {1'b0, nb_now};
	assign bad_idx = (req_q.set_a == 8'd0) || (req_q.set_a > 8'(MAX_SETS)) ||
		(req_q.set_b == 8'd0) || (req_q.set_b > 8'(MAX_SETS));
	assign table_full = closed_q >= SW'(MAX_SETS);
	assign hit_now = cmp_vld_q && (elem_rd == req_q.value);

	assign open_zero = (state_q == S_DECODE) && (req_q.mode == sml_pkg::MODE_OPEN) &&
		!building_q && !table_full && (req_q.declared_size == 6'd0);
	assign elem_we = (state_q == S_SCAN_DONE) && (req_q.mode == sml_pkg::MODE_ADD) &&
		(hit_q == '0);
	assign add_close = elem_we && ((fill_q + SZW'(1)) >= target_q);
	assign size_we = open_zero || add_close;
	assign size_wdata = open_zero ? '0 : target_q;

	always_comb begin
		unique case (state_q)
			S_LSZA:  size_raddr = sa_idx[SIW-1:0];
			S_LSZB:  size_raddr = sb_idx[SIW-1:0];
			default: size_raddr = s_q[SIW-1:0];
		endcase
	end

	always_comb begin
		ld.load = 1'b0;
		ld.item = res_q;
		if (state_q == S_RESP) begin
			ld.load = out_free;
		end else if (state_q == S_LOUT) begin
			ld.load = out_free;
			ld.item = '{status: sml_pkg::ST_OK, set_number: '0, element: elem_rd,
				last: (rem_q == (SZW+1)'(1)), set_closed: 1'b0};
		end
	end

	sml_ram #(.WIDTH(16), .DEPTH(ELEM_DEPTH)) u_elem_ram (
		.clk   (clk),
		.we    (elem_we),
		.waddr ({closed_q[SIW-1:0], fill_q[EW-1:0]}),
		.wdata (req_q.value),
		.raddr ({s_q[SIW-1:0], e_q[EW-1:0]}),
		.rdata (elem_rd)
	);

	sml_ram #(.WIDTH(SZW), .DEPTH(MAX_SETS)) u_size_ram (
		.clk   (clk),
		.we    (size_we),
		.waddr (closed_q[SIW-1:0]),
		.wdata (size_wdata),
		.raddr (size_raddr),
		.rdata (size_rd)
	);

	sml_out_stage u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.ld     (ld),
		.free   (out_free),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			closed_q   <= '0;
			building_q <= 1'b0;
			target_q   <= '0;
			fill_q     <= '0;
			cmp_vld_q  <= 1'b0;
			req_q      <= '0;
			res_q      <= '0;
			s_q        <= '0;
			e_q        <= '0;
			lim_q      <= '0;
			cmp_set_q  <= '0;
			hit_q      <= '0;
			na_q       <= '0;
			nb_q       <= '0;
			rem_q      <= '0;
		end else begin
			cmp_vld_q <= (state_q == S_ELEM) && !hit_now;
			if (hit_now) begin
				hit_q   <= SW'(cmp_set_q) + SW'(1);
				state_q <= S_SCAN_DONE;
			end else begin
				unique case (state_q)
					S_IDLE: begin
						if (item.valid) begin
							req_q   <= item.data;
							state_q <= S_DECODE;
						end
					end
					S_DECODE: begin
						s_q <= '0;
						unique case (req_q.mode)
							sml_pkg::MODE_OPEN: begin
								state_q <= S_RESP;
								priority if (building_q) begin
									res_q <= mk_res(sml_pkg::ST_BUSY, '0, 1'b0);
								end else if (table_full) begin
									res_q <= mk_res(sml_pkg::ST_FULL, '0, 1'b0);
								end else if (req_q.declared_size > 6'(SET_CAP)) begin
									res_q <= mk_res(sml_pkg::ST_TOOLARGE, '0, 1'b0);
								end else if (req_q.declared_size == 6'd0) begin
									closed_q <= closed_q + SW'(1);
									res_q    <= mk_res(sml_pkg::ST_OK, '0, 1'b1);
								end else begin
									building_q <= 1'b1;
									target_q   <= SZW'(req_q.declared_size);
									fill_q     <= '0;
									res_q      <= mk_res(sml_pkg::ST_OK, '0, 1'b0);
								end
							end
							sml_pkg::MODE_ADD: begin
								if (!building_q || table_full) begin
									res_q   <= mk_res(sml_pkg::ST_NOOPEN, '0, 1'b0);
									state_q <= S_RESP;
								end else begin
									state_q <= S_SIZE;
								end
							end
							sml_pkg::MODE_FIND: begin
								state_q <= S_SIZE;
							end
							sml_pkg::MODE_LIST: begin
								if (bad_idx) begin
									res_q   <= mk_res(sml_pkg::ST_BADIDX, '0, 1'b0);
									state_q <= S_RESP;
								end else begin
									state_q <= S_LSZA;
								end
							end
							default: state_q <= S_IDLE;
						endcase
					end
					S_SIZE: begin
						if (s_q >= closed_q) begin
							hit_q   <= '0;
							state_q <= S_SCAN_DONE;
						end else begin
							state_q <= S_SIZE_CHK;
						end
					end
					S_SIZE_CHK: begin
						if (size_rd == '0) begin
							s_q     <= s_q + SW'(1);
							state_q <= S_SIZE;
						end else begin
							e_q     <= '0;
							lim_q   <= size_rd;
							state_q <= S_ELEM;
						end
					end
					S_ELEM: begin
						cmp_set_q <= s_q[SIW-1:0];
						if ((e_q + SZW'(1)) == lim_q) begin
							s_q     <= s_q + SW'(1);
							state_q <= S_SIZE;
						end else begin
							e_q <= e_q + SZW'(1);
						end
					end
					S_SCAN_DONE: begin
						state_q <= S_RESP;
						priority if (req_q.mode == sml_pkg::MODE_FIND) begin
							res_q <= mk_res((hit_q != '0) ? sml_pkg::ST_OK :
								sml_pkg::ST_NOTFOUND, hit_q, 1'b0);
						end else if (hit_q != '0) begin
							res_q <= mk_res(sml_pkg::ST_DUP, hit_q, 1'b0);
						end else if (add_close) begin
							closed_q   <= closed_q + SW'(1);
							building_q <= 1'b0;
							fill_q     <= '0;
							target_q   <= '0;
							res_q      <= mk_res(sml_pkg::ST_OK, '0, 1'b1);
						end else begin
							fill_q <= fill_q + SZW'(1);
							res_q  <= mk_res(sml_pkg::ST_OK, '0, 1'b0);
						end
					end
					S_RESP: begin
						if (out_free) begin
							state_q <= S_IDLE;
						end
					end
					S_LSZA: begin
						state_q <= S_LSZB;
					end
					S_LSZB: begin
						na_q    <= sa_live ? size_rd : '0;
						state_q <= S_LSTART;
					end
					S_LSTART: begin
						nb_q  <= nb_now;
						rem_q <= tot_now;
						if (tot_now == '0) begin
							res_q   <= mk_res(sml_pkg::ST_OK, '0, 1'b0);
							state_q <= S_RESP;
						end else begin
							s_q     <= SW'(sa_idx);
							e_q     <= '0;
							lim_q   <= na_q;
							state_q <= S_LREQ;
						end
					end
					S_LREQ: begin
						if (e_q == lim_q) begin
							s_q   <= SW'(sb_idx);
							e_q   <= '0;
							lim_q <= nb_q;
						end else begin
							state_q <= S_LOUT;
						end
					end
					S_LOUT: begin
						if (out_free) begin
							rem_q <= rem_q - (SZW+1)'(1);
							e_q   <= e_q + SZW'(1);
							state_q <= (rem_q == (SZW+1)'(1)) ? S_IDLE : S_LREQ;
						end
					end
					default: state_q <= S_IDLE;
				endcase
			end
		end
	end

endmodule

@@ sv/sml_chk.sv @@
// ----------------------------------------------------------------------------
// sml_chk: port checker of the set membership table
// Watches both channels of the top level; attached by bind.
// ----------------------------------------------------------------------------
module sml_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               item_valid,
	input logic               item_ready,
	input logic               res_valid,
	input logic               res_ready,
	input sml_pkg::out_item_t res_data
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_data))
		else $error("result item changed while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("ready right after an accepted item");

	a_error_single: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_data.status != sml_pkg::ST_OK) |->
			res_data.last && !res_data.set_closed && (res_data.element == 16'd0))
		else $error("error result not a single plain item");

	a_element_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_data.element != 16'd0) |->
			(res_data.set_number == '0) && !res_data.set_closed)
		else $error("listing result carries set fields");

endmodule

bind set_membership_table_unit sml_chk u_sml_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.item_valid (item.valid),
	.item_ready (item.ready),
	.res_valid  (result.valid),
	.res_ready  (result.ready),
	.res_data   (result.data)
);

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb: testbench of the set membership table unit
// Directed and random open, add, find and list items go through a shadow
// table that predicts every result item; results are checked in order under
// random stalls on both channels, with one long hold on the result side.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

	localparam int MAX_SETS      = 16;
	localparam int SET_CAP       = 32;
	localparam int ITEM_TOTAL    = 310;
	localparam int QUIET_FROM    = 270;
	localparam int HOLD_AT       = 40;
	localparam int HOLD_CYCLES   = 400;
	localparam int STALL_LIMIT   = 4000;
	localparam int DRAIN_CYCLES  = 40;

	class set_table_scoreboard;
		logic [15:0] store [MAX_SETS*SET_CAP];
		int unsigned sizes [MAX_SETS];
		int unsigned closed;
		bit          building;
		int unsigned target;
		int unsigned fill;
		sml_pkg::out_item_t expected_q [$];
		int          fails;

		function new();
			foreach (sizes[i]) sizes[i] = 0;
			foreach (store[i]) store[i] = '0;
			closed   = 0;
			building = 0;
			target   = 0;
			fill     = 0;
			fails    = 0;
		endfunction

		function int unsigned owner_of(logic [15:0] v);
			for (int unsigned s = 0; s < closed && s < MAX_SETS; s++)
				for (int unsigned e = 0; e < sizes[s] && e < SET_CAP; e++)
					if (store[s*SET_CAP+e] == v)
						return s + 1;
			return 0;
		endfunction

		function int unsigned size_of(int unsigned s);
			if (s >= closed || s >= MAX_SETS)
				return 0;
			return (sizes[s] > SET_CAP) ? SET_CAP : sizes[s];
		endfunction

		function void push(sml_pkg::status_t st, int unsigned setno, logic [15:0] elem,
				bit fin, bit done);
			sml_pkg::out_item_t r;
			r.status     = st;
			r.set_number = sml_pkg::setno_t'(setno);
			r.element    = elem;
			r.last       = fin;
			r.set_closed = done;
			expected_q.push_back(r);
		endfunction

		function void note_input(sml_pkg::in_item_t it);
			int unsigned hit;
			int unsigned na;
			int unsigned nb;
			int unsigned k;
			case (sml_pkg::mode_t'(it.mode))
				sml_pkg::MODE_OPEN: begin
					if (building)
						push(sml_pkg::ST_BUSY, 0, 0, 1, 0);
					else if (closed >= MAX_SETS)
						push(sml_pkg::ST_FULL, 0, 0, 1, 0);
					else if (it.declared_size > SET_CAP)
						push(sml_pkg::ST_TOOLARGE, 0, 0, 1, 0);
					else if (it.declared_size == 0) begin
						sizes[closed] = 0;
						closed++;
						push(sml_pkg::ST_OK, 0, 0, 1, 1);
					end else begin
						building = 1;
						target   = it.declared_size;
						fill     = 0;
						push(sml_pkg::ST_OK, 0, 0, 1, 0);
					end
				end
				sml_pkg::MODE_ADD: begin
					if (!building || closed >= MAX_SETS) begin
						push(sml_pkg::ST_NOOPEN, 0, 0, 1, 0);
					end else begin
						hit = owner_of(it.value);
						if (hit != 0) begin
							push(sml_pkg::ST_DUP, hit, 0, 1, 0);
						end else begin
							if (fill < SET_CAP)
								store[closed*SET_CAP+fill] = it.value;
							fill++;
							if (fill >= target) begin
								sizes[closed] = target;
								closed++;
								building = 0;
								fill     = 0;
								target   = 0;
								push(sml_pkg::ST_OK, 0, 0, 1, 1);
							end else begin
								push(sml_pkg::ST_OK, 0, 0, 1, 0);
							end
						end
					end
				end
				sml_pkg::MODE_FIND: begin
					hit = owner_of(it.value);
					push(hit != 0 ? sml_pkg::ST_OK : sml_pkg::ST_NOTFOUND, hit, 0, 1, 0);
				end
				default: begin
					if (it.set_a < 1 || it.set_a > MAX_SETS ||
							it.set_b < 1 || it.set_b > MAX_SETS) begin
						push(sml_pkg::ST_BADIDX, 0, 0, 1, 0);
					end else begin
						na = size_of(it.set_a - 1);
						nb = size_of(it.set_b - 1);
						if (na + nb == 0) begin
							push(sml_pkg::ST_OK, 0, 0, 1, 0);
						end else begin
							k = 0;
							for (int unsigned e = 0; e < na; e++, k++)
								push(sml_pkg::ST_OK, 0, store[(it.set_a-1)*SET_CAP+e],
									k + 1 == na + nb, 0);
							for (int unsigned e = 0; e < nb; e++, k++)
								push(sml_pkg::ST_OK, 0, store[(it.set_b-1)*SET_CAP+e],
									k + 1 == na + nb, 0);
						end
					end
				end
			endcase
		endfunction

		function void compare_field(string name, int unsigned exp_v,
				int unsigned got_v);
			if (exp_v != got_v) begin
				$display("%0t: %s mismatch: expected %0d, actual %0d",
					$time, name, exp_v, got_v);
				fails++;
			end
		endfunction

		function void check_result(sml_pkg::out_item_t got);
			sml_pkg::out_item_t exp_r;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result item: expected none, actual %p",
					$time, got);
				fails++;
				return;
			end
			exp_r = expected_q.pop_front();
			compare_field("status", exp_r.status, got.status);
			compare_field("set_number", exp_r.set_number, got.set_number);
			compare_field("element", exp_r.element, got.element);
			compare_field("last", exp_r.last, got.last);
			compare_field("set_closed", exp_r.set_closed, got.set_closed);
		endfunction
	endclass

	logic clk;
	logic arst_n;

	sml_in_if  item_ch ();
	sml_out_if result_ch ();

	set_membership_table_unit #(
		.MAX_SETS(MAX_SETS),
		.SET_CAP (SET_CAP)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.item  (item_ch),
		.result(result_ch)
	);

	set_table_scoreboard table_sb;
	int sent_count;
	bit quiet;
	bit held;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		table_sb         = new();
		sent_count       = 0;
		quiet            = 0;
		held             = 0;
		arst_n           = 1'b0;
		item_ch.valid    = 1'b0;
		item_ch.data     = '0;
		result_ch.ready  = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
	end

	function automatic sml_pkg::in_item_t make_item(sml_pkg::mode_t m, logic [15:0] v,
			logic [5:0] ds, logic [7:0] a, logic [7:0] b);
		sml_pkg::in_item_t it;
		it.mode          = m;
		it.value         = v;
		it.declared_size = ds;
		it.set_a         = a;
		it.set_b         = b;
		return it;
	endfunction

	function automatic logic [15:0] pick_stored(output bit found);
		int unsigned filled [$];
		int unsigned s;
		for (int unsigned i = 0; i < table_sb.closed; i++)
			if (table_sb.sizes[i] != 0)
				filled.push_back(i);
		found = filled.size() != 0;
		if (!found)
			return 16'($urandom);
		s = filled[$urandom_range(0, filled.size() - 1)];
		return table_sb.store[s*SET_CAP + $urandom_range(0, table_sb.sizes[s] - 1)];
	endfunction

	task automatic send(sml_pkg::in_item_t it);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			item_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.data  <= it;
		do @(posedge clk); while (!item_ch.ready);
		table_sb.note_input(it);
		sent_count++;
		quiet = sent_count >= QUIET_FROM;
	endtask

	task automatic send_directed();
		send(make_item(sml_pkg::MODE_LIST, 16'h0000, 6'd0, 8'd1, 8'd2));
		send(make_item(sml_pkg::MODE_LIST, 16'h0000, 6'd0, 8'd0, 8'd1));
		send(make_item(sml_pkg::MODE_LIST, 16'h0000, 6'd0, 8'd1, 8'd17));
		send(make_item(sml_pkg::MODE_LIST, 16'h0000, 6'd0, 8'd255, 8'd3));
		send(make_item(sml_pkg::MODE_ADD, 16'h1234, 6'd0, 8'd0, 8'd0));
		send(make_item(sml_pkg::MODE_FIND, 16'h0000, 6'd0, 8'd0, 8'd0));
		send(make_item(sml_pkg::MODE_OPEN, 16'h0000, 6'd33, 8'd0, 8'd0));
		send(make_item(sml_pkg::MODE_OPEN, 16'h0000, 6'd63, 8'd0, 8'd0));
		send(make_item(sml_pkg::MODE_OPEN, 16'h0000, 6'd0, 8'd0, 8'd0));
		send(make_item(sml_pkg::MODE_OPEN, 16'h0000, 6'd2, 8'd0, 8'd0));
		send(make_item(sml_pkg::MODE_OPEN, 16'h0000, 6'd4, 8'd0, 8'd0));
		send(make_item(sml_pkg::MODE_LIST, 16'h0000, 6'd0, 8'd2, 8'd1));
		send(make_item(sml_pkg::MODE_ADD, 16'h0000, 6'd0, 8'd0, 8'd0));
		send(make_item(sml_pkg::MODE_ADD, 16'hFFFF, 6'd0, 8'd0, 8'd0));
		send(make_item(sml_pkg::MODE_OPEN, 16'h0000, 6'd3, 8'd0, 8'd0));
		send(make_item(sml_pkg::MODE_ADD, 16'h0000, 6'd0, 8'd0, 8'd0));
		send(make_item(sml_pkg::MODE_ADD, 16'hFFFF, 6'd0, 8'd0, 8'd0));
		send(make_item(sml_pkg::MODE_ADD, 16'h8000, 6'd0, 8'd0, 8'd0));
		send(make_item(sml_pkg::MODE_ADD, 16'h5555, 6'd0, 8'd0, 8'd0));
		send(make_item(sml_pkg::MODE_ADD, 16'hAAAA, 6'd0, 8'd0, 8'd0));
		send(make_item(sml_pkg::MODE_FIND, 16'hFFFF, 6'd0, 8'd0, 8'd0));
		send(make_item(sml_pkg::MODE_FIND, 16'hAAAA, 6'd0, 8'd0, 8'd0));
		send(make_item(sml_pkg::MODE_LIST, 16'h0000, 6'd0, 8'd2, 8'd3));
		send(make_item(sml_pkg::MODE_LIST, 16'h0000, 6'd0, 8'd16, 8'd1));
		send(make_item(sml_pkg::MODE_LIST, 16'h0000, 6'd0, 8'd3, 8'd3));
	endtask

	task automatic send_random();
		int unsigned pick;
		int unsigned sz;
		bit found;
		logic [15:0] v;
		while (sent_count < ITEM_TOTAL) begin
			pick = $urandom_range(0, 99);
			if (!table_sb.building && table_sb.closed < MAX_SETS && pick < 55) begin
				case ($urandom_range(0, 15))
					0:       sz = 0;
					1, 2:    sz = SET_CAP;
					3:       sz = $urandom_range(SET_CAP + 1, 63);
					default: sz = $urandom_range(1, 6);
				endcase
				send(make_item(sml_pkg::MODE_OPEN, 16'($urandom), 6'(sz), 8'($urandom),
					8'($urandom)));
			end else if (table_sb.building && pick < 85) begin
				v = 16'($urandom);
				if ($urandom_range(0, 3) == 0)
					v = pick_stored(found);
				send(make_item(sml_pkg::MODE_ADD, v, 6'($urandom), 8'($urandom),
					8'($urandom)));
			end else begin
				case ($urandom_range(0, 5))
					0: send(make_item(sml_pkg::MODE_FIND, 16'($urandom), 6'($urandom),
						8'($urandom), 8'($urandom)));
					1: send(make_item(sml_pkg::MODE_FIND, pick_stored(found), 6'($urandom),
						8'($urandom), 8'($urandom)));
					2, 3: send(make_item(sml_pkg::MODE_LIST, 16'($urandom), 6'($urandom),
						8'($urandom_range(1, MAX_SETS)), 8'($urandom_range(1, MAX_SETS))));
					default: send(make_item(sml_pkg::mode_t'($urandom_range(0, 3)),
						16'($urandom), 6'($urandom_range(0, 63)),
						8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))));
				endcase
			end
		end
	endtask

	initial begin
		@(posedge arst_n);
		@(posedge clk);
		send_directed();
		send_random();
		item_ch.valid <= 1'b0;
		while (table_sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (table_sb.fails == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		int stall_left;
		stall_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (result_ch.valid && result_ch.ready)
				table_sb.check_result(result_ch.data);
			if (!held && sent_count >= HOLD_AT) begin
				held       = 1;
				stall_left = HOLD_CYCLES;
			end
			if (stall_left > 0) begin
				stall_left--;
				result_ch.ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 12) - 1;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	initial begin
		int idle_cycles;
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

endmodule
